[design/vna_pkg.sv]
// Shared types and constants for the vertex normal accumulator.
package vna_pkg;

  localparam int IDX_W             = 10;
  localparam int POS_W             = 16;
  localparam int NORM_W            = 16;
  localparam int IN_DATA_W         = 80;
  localparam int OUT_DATA_W        = 64;
  localparam int DEF_MAX_VERTICES  = 1024;
  localparam int DEF_ACCUM_BITS    = 48;

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_TRI   = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POS_RD,
    ST_CROSS,
    ST_FACE,
    ST_ACC_RD,
    ST_ACC_WR,
    ST_RD_ACC,
    ST_RD_MAG,
    ST_SCALE,
    ST_SQUARE,
    ST_SQRT,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

[design/vertex_normal_accumulator.sv]
// Area-weighted vertex normal accumulator built around position and accumulator memories.
//
// Requests arrive on the in_ channel; in_tuser carries the request kind (load vertex, add
// triangle, read normal). A load writes the position and clears the accumulator of one vertex.
// A triangle reads its three corner positions from the position memory (one read per cycle),
// forms the face normal with six multipliers, and then performs three read-modify-write
// passes on the accumulator memory, one per corner, before the next request can be taken.
// A read fetches the accumulator and scales the largest lane into [2^29, 2^30) one bit per
// cycle, sums the squares, takes the integer square root and divides the three lanes in
// parallel with a restoring divider; a zero vector goes straight to the output register.
// One request is worked on at a time; in_tready is high only while the sequencer is idle.
// The result sits in an output register; while the receiver stalls, loads and triangles are
// still taken, and a further read waits in its last step until the register is free.
// Reset clears the sequencer and the output valid flag only; the memory contents are
// undefined until a vertex has been loaded.
module vertex_normal_accumulator #(
  parameter int MAX_VERTICES = vna_pkg::DEF_MAX_VERTICES,
  parameter int ACCUM_BITS   = vna_pkg::DEF_ACCUM_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // vertex_index, pos_x, pos_y, pos_z, corner_b, corner_c, then zero padding
  input  logic [vna_pkg::IN_DATA_W-1:0]  in_tdata,
  // req_type
  input  logic [1:0]                     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // read_index, normal_x, normal_y, normal_z, then zero padding
  output logic [vna_pkg::OUT_DATA_W-1:0] out_tdata,
  // zero_length
  output logic [0:0]                     out_tuser
);
  import vna_pkg::*;

  localparam int AW   = $clog2(MAX_VERTICES);
  localparam int AB   = ACCUM_BITS;
  localparam int DW   = POS_W + 1;
  localparam int PW   = 2 * DW;
  localparam int NW   = PW + 1;
  localparam int SW   = 62;
  localparam int RW   = 32;
  localparam int QW   = 16;
  localparam int DVW  = 47;
  localparam int FRAC = 14;

  state_t state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;

  logic              in_acc;
  logic [IDX_W-1:0]  in_idx;
  logic [IDX_W-1:0]  ia_r, ib_r, ic_r;
  logic              ok_r;
  logic [IDX_W-1:0]  corner;

  logic [3*POS_W-1:0] pos_mem [MAX_VERTICES];
  logic [3*AB-1:0]    acc_mem [MAX_VERTICES];
  logic [3*POS_W-1:0] pos_q_r;
  logic [3*AB-1:0]    acc_q_r;
  logic               pos_we, acc_we;
  logic [AW-1:0]      pos_raddr, acc_raddr, acc_waddr;
  logic [3*AB-1:0]    acc_wdata;

  logic [3*POS_W-1:0] pa_r, pb_r, pc_r;
  logic signed [DW-1:0] ax, ay, az, bx, by, bz;
  logic signed [PW-1:0] p_aybz_r, p_azby_r, p_azbx_r, p_axbz_r, p_axby_r, p_aybx_r;
  logic signed [NW-1:0] nx_r, ny_r, nz_r;

  logic [AB-1:0] m0_r, m1_r, m2_r, mx_r;
  logic [AB-1:0] m0_c, m1_c, m2_c, mx_c;
  logic [2:0]    sgn_r;
  logic          zf_r;
  logic [29:0]   msel;
  logic [59:0]   sq;
  logic [SW-1:0] s_r;
  logic [SW-1:0] rt_rem_r, rt_res_r, rt_bit_r;
  logic [SW-1:0] rt_try, rt_rem_nxt, rt_res_nxt;
  logic [RW-1:0] root;
  logic [DVW-1:0] dv_r, dn0_r, dn1_r, dn2_r;
  logic [QW-1:0]  q0_r, q1_r, q2_r;

  logic              out_tvalid_r;
  logic [IDX_W-1:0]  read_index_r;
  logic [NORM_W-1:0] normal_x_r, normal_y_r, normal_z_r;
  logic              zero_length_r;
  logic              out_load;

  function automatic logic idx_ok(logic [IDX_W-1:0] i);
    return 32'(i) < 32'(MAX_VERTICES);
  endfunction

  function automatic logic [AB-1:0] sat_add(logic [AB-1:0] a, logic signed [NW-1:0] n);
    logic signed [AB:0] s;
    s = (AB+1)'($signed(a)) + (AB+1)'(n);
    if (s[AB] != s[AB-1]) begin
      return s[AB] ? {1'b1, {(AB-1){1'b0}}} : {1'b0, {(AB-1){1'b1}}};
    end
    return s[AB-1:0];
  endfunction

  function automatic logic [AB-1:0] mag(logic [AB-1:0] c, logic ok);
    if (!ok) begin
      return '0;
    end
    return c[AB-1] ? (~c + AB'(1)) : c;
  endfunction

  function automatic logic [NORM_W-1:0] apply_sign(logic [QW-1:0] q, logic neg, logic zf);
    if (zf) begin
      return '0;
    end
    return neg ? NORM_W'(-q) : NORM_W'(q);
  endfunction

  assign in_acc = in_tvalid && in_tready;
  assign in_idx = in_tdata[9:0];

  always_comb begin
    case (cnt_r[1:0])
      2'd0:    corner = ia_r;
      2'd1:    corner = ib_r;
      2'd2:    corner = ic_r;
      default: corner = ia_r;
    endcase
  end

  // Next state and step counter.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (in_acc) begin
          case (in_tuser)
            REQ_TRI: begin
              if (idx_ok(in_idx) && idx_ok(in_tdata[67:58]) && idx_ok(in_tdata[77:68])) begin
                state_nxt = ST_POS_RD;
              end
            end
            REQ_READ: state_nxt = ST_RD_ACC;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_POS_RD: begin
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd3) begin
          state_nxt = ST_CROSS;
        end
      end
      ST_CROSS: state_nxt = ST_FACE;
      ST_FACE: begin
        state_nxt = ST_ACC_RD;
        cnt_nxt   = '0;
      end
      ST_ACC_RD: state_nxt = ST_ACC_WR;
      ST_ACC_WR: begin
        cnt_nxt   = cnt_r + 5'd1;
        state_nxt = (cnt_r == 5'd2) ? ST_IDLE : ST_ACC_RD;
      end
      ST_RD_ACC: state_nxt = ST_RD_MAG;
      ST_RD_MAG: state_nxt = (mx_c == '0) ? ST_OUT : ST_SCALE;
      ST_SCALE: begin
        if (!(|mx_r[AB-1:30]) && mx_r[29]) begin
          state_nxt = ST_SQUARE;
          cnt_nxt   = '0;
        end
      end
      ST_SQUARE: begin
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd2) begin
          state_nxt = ST_SQRT;
          cnt_nxt   = '0;
        end
      end
      ST_SQRT: begin
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd30) begin
          state_nxt = ST_DIV;
          cnt_nxt   = '0;
        end
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd15) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Handshake and memory port controls.
  always_comb begin
    in_tready = (state_r == ST_IDLE);
    out_load  = (state_r == ST_OUT) && (!out_tvalid_r || out_tready);
    pos_we    = in_acc && (in_tuser == REQ_LOAD) && idx_ok(in_idx);
    pos_raddr = AW'(corner);
    acc_raddr = (state_r == ST_RD_ACC) ? AW'(ia_r) : AW'(corner);
    if (state_r == ST_ACC_WR) begin
      acc_we    = 1'b1;
      acc_waddr = AW'(corner);
      acc_wdata = {sat_add(acc_q_r[3*AB-1:2*AB], nz_r),
                   sat_add(acc_q_r[2*AB-1:AB], ny_r),
                   sat_add(acc_q_r[AB-1:0], nx_r)};
    end else begin
      acc_we    = pos_we;
      acc_waddr = AW'(in_idx);
      acc_wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[AW'(in_idx)] <= in_tdata[57:10];
    end
    pos_q_r <= pos_mem[pos_raddr];
  end

  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_mem[acc_waddr] <= acc_wdata;
    end
    acc_q_r <= acc_mem[acc_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Edge vectors of the face: a runs from p2 to p3, b from p2 to p1.
  always_comb begin
    ax = DW'($signed(pc_r[15:0]))  - DW'($signed(pb_r[15:0]));
    ay = DW'($signed(pc_r[31:16])) - DW'($signed(pb_r[31:16]));
    az = DW'($signed(pc_r[47:32])) - DW'($signed(pb_r[47:32]));
    bx = DW'($signed(pa_r[15:0]))  - DW'($signed(pb_r[15:0]));
    by = DW'($signed(pa_r[31:16])) - DW'($signed(pb_r[31:16]));
    bz = DW'($signed(pa_r[47:32])) - DW'($signed(pb_r[47:32]));
  end

  always_comb begin
    m0_c = mag(acc_q_r[AB-1:0], ok_r);
    m1_c = mag(acc_q_r[2*AB-1:AB], ok_r);
    m2_c = mag(acc_q_r[3*AB-1:2*AB], ok_r);
    mx_c = (m1_c > m0_c) ? m1_c : m0_c;
    mx_c = (m2_c > mx_c) ? m2_c : mx_c;
    case (cnt_r[1:0])
      2'd0:    msel = m0_r[29:0];
      2'd1:    msel = m1_r[29:0];
      default: msel = m2_r[29:0];
    endcase
    sq = msel * msel;
    rt_try = rt_res_r + rt_bit_r;
    if (rt_rem_r >= rt_try) begin
      rt_rem_nxt = rt_rem_r - rt_try;
      rt_res_nxt = (rt_res_r >> 1) + rt_bit_r;
    end else begin
      rt_rem_nxt = rt_rem_r;
      rt_res_nxt = rt_res_r >> 1;
    end
    root = rt_res_nxt[RW-1:0];
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ia_r <= in_idx;
      ib_r <= in_tdata[67:58];
      ic_r <= in_tdata[77:68];
      ok_r <= idx_ok(in_idx);
    end
    case (state_r)
      ST_POS_RD: begin
        case (cnt_r[1:0])
          2'd1:    pa_r <= pos_q_r;
          2'd2:    pb_r <= pos_q_r;
          2'd3:    pc_r <= pos_q_r;
          default: pa_r <= pa_r;
        endcase
      end
      ST_CROSS: begin
        p_aybz_r <= ay * bz;
        p_azby_r <= az * by;
        p_azbx_r <= az * bx;
        p_axbz_r <= ax * bz;
        p_axby_r <= ax * by;
        p_aybx_r <= ay * bx;
      end
      ST_FACE: begin
        nx_r <= NW'(p_aybz_r) - NW'(p_azby_r);
        ny_r <= NW'(p_azbx_r) - NW'(p_axbz_r);
        nz_r <= NW'(p_axby_r) - NW'(p_aybx_r);
      end
      ST_RD_MAG: begin
        m0_r  <= m0_c;
        m1_r  <= m1_c;
        m2_r  <= m2_c;
        mx_r  <= mx_c;
        zf_r  <= (mx_c == '0);
        sgn_r <= {acc_q_r[3*AB-1], acc_q_r[2*AB-1], acc_q_r[AB-1]} & {3{ok_r}};
        s_r   <= '0;
      end
      ST_SCALE: begin
        // Bring the largest magnitude into [2^29, 2^30), one bit a cycle.
        if (|mx_r[AB-1:30]) begin
          m0_r <= m0_r >> 1;
          m1_r <= m1_r >> 1;
          m2_r <= m2_r >> 1;
          mx_r <= mx_r >> 1;
        end else if (!mx_r[29]) begin
          m0_r <= m0_r << 1;
          m1_r <= m1_r << 1;
          m2_r <= m2_r << 1;
          mx_r <= mx_r << 1;
        end
      end
      ST_SQUARE: begin
        s_r <= s_r + SW'(sq);
        if (cnt_r == 5'd2) begin
          rt_rem_r <= s_r + SW'(sq);
          rt_res_r <= '0;
          rt_bit_r <= SW'(1) << 60;
        end
      end
      ST_SQRT: begin
        rt_rem_r <= rt_rem_nxt;
        rt_res_r <= rt_res_nxt;
        rt_bit_r <= rt_bit_r >> 2;
        if (cnt_r == 5'd30) begin
          // Rounded quotient: the dividend carries half the divisor.
          dv_r  <= DVW'(root) << 15;
          dn0_r <= DVW'({m0_r[29:0], {FRAC{1'b0}}}) + DVW'(root >> 1);
          dn1_r <= DVW'({m1_r[29:0], {FRAC{1'b0}}}) + DVW'(root >> 1);
          dn2_r <= DVW'({m2_r[29:0], {FRAC{1'b0}}}) + DVW'(root >> 1);
          q0_r  <= '0;
          q1_r  <= '0;
          q2_r  <= '0;
        end
      end
      ST_DIV: begin
        dv_r <= dv_r >> 1;
        if (dn0_r >= dv_r) begin
          dn0_r <= dn0_r - dv_r;
          q0_r  <= {q0_r[QW-2:0], 1'b1};
        end else begin
          q0_r  <= {q0_r[QW-2:0], 1'b0};
        end
        if (dn1_r >= dv_r) begin
          dn1_r <= dn1_r - dv_r;
          q1_r  <= {q1_r[QW-2:0], 1'b1};
        end else begin
          q1_r  <= {q1_r[QW-2:0], 1'b0};
        end
        if (dn2_r >= dv_r) begin
          dn2_r <= dn2_r - dv_r;
          q2_r  <= {q2_r[QW-2:0], 1'b1};
        end else begin
          q2_r  <= {q2_r[QW-2:0], 1'b0};
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      read_index_r  <= ia_r;
      normal_x_r    <= apply_sign(q0_r, sgn_r[0], zf_r);
      normal_y_r    <= apply_sign(q1_r, sgn_r[1], zf_r);
      normal_z_r    <= apply_sign(q2_r, sgn_r[2], zf_r);
      zero_length_r <= zf_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {6'd0, normal_z_r, normal_y_r, normal_x_r, read_index_r};
  assign out_tuser  = zero_length_r;

endmodule
